### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/alrg_pkg.sv
// ----------------------------------------------------------------------------
// alrg_pkg
// Constants, types and the external-lag table of the lagged generator.
// ----------------------------------------------------------------------------
package alrg_pkg;

  // Ring geometry
  localparam int RING_LEN = 33;
  localparam int IDX_W    = 6;
  typedef logic [IDX_W-1:0] ring_idx_t;
  typedef logic [31:0]      word_t;
  typedef logic [3:0]       lag_t;

  localparam ring_idx_t RING_LAST = ring_idx_t'(RING_LEN - 1);
  localparam ring_idx_t START_POS = ring_idx_t'(15);

  // Lag selection
  localparam int   LAG_EXT_MUL  = 59;
  localparam int   LAG_EXT_MOD  = 9;
  localparam lag_t LAG_NORMAL   = lag_t'(9);
  localparam lag_t LAG_EXT_BASE = lag_t'(6);

  // Seeding chain
  localparam word_t LCG_MUL    = 32'h46A2_E297;
  localparam word_t LCG_ADD    = 32'h00EF_353B;
  localparam word_t RESET_SEED = 32'd34057;

  // (byte * 59) mod 9 for every byte value, built at elaboration
  typedef logic [255:0][3:0] ext_lag_tbl_t;

  function automatic ext_lag_tbl_t build_ext_lag();
    ext_lag_tbl_t tbl;
    for (int i = 0; i < 256; i++) begin
      tbl[i] = 4'((i * LAG_EXT_MUL) % LAG_EXT_MOD);
    end
    return tbl;
  endfunction

  localparam ext_lag_tbl_t EXT_LAG_TBL = build_ext_lag();

  // Controller to datapath commands
  typedef struct packed {
    logic load_seed;   // latch seed, mode, restart fill index and pointer
    logic fill_step;   // write one chain word and step the chain
    logic rd_en;       // register the two ring reads of a draw
    logic load_out;    // write back the sum, load output, advance pointer
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill_last;   // fill index is on the last ring word
  } dp_stat_t;

endpackage

### rtl/core/alrg_dp.sv
// ----------------------------------------------------------------------------
// alrg_dp
// Ring memory, pointer, seeding chain and adder of the lagged generator.
// ----------------------------------------------------------------------------
module alrg_dp import alrg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  word_t     seed_value,
  input  logic      use_external,
  input  logic [7:0] external_byte,
  output word_t     random_value
);

  `include "assert_macros.svh"

  word_t     ring_mem [RING_LEN];
  word_t     rd_a_r;
  word_t     rd_b_r;
  word_t     lcg_r,  lcg_nxt;
  ring_idx_t fill_idx_r, fill_idx_nxt;
  ring_idx_t pos_r,  pos_nxt;
  logic      ext_r,  ext_nxt;
  word_t     out_r;
  word_t     lcg_prod;
  word_t     sum;
  lag_t      lag;
  ring_idx_t other_raw;
  ring_idx_t other_idx;
  ring_idx_t wr_addr;
  word_t     wr_data;
  logic      wr_en;

  // Lag and partner index of a draw
  always_comb begin
    lag       = ext_r ? (LAG_EXT_BASE + EXT_LAG_TBL[external_byte]) : LAG_NORMAL;
    other_raw = pos_r + ring_idx_t'(lag);
    other_idx = (other_raw > RING_LAST) ? (other_raw - ring_idx_t'(RING_LEN)) : other_raw;
  end

  // Seeding chain step and draw sum
  always_comb begin
    lcg_prod = lcg_r * LCG_MUL;
    lcg_nxt  = lcg_r;
    if (cmd.load_seed) begin
      lcg_nxt = seed_value;
    end else if (cmd.fill_step) begin
      lcg_nxt = lcg_prod + LCG_ADD;
    end
    sum = rd_a_r + rd_b_r;
  end

  // Pointer, fill index and mode
  always_comb begin
    pos_nxt      = pos_r;
    fill_idx_nxt = fill_idx_r;
    ext_nxt      = ext_r;
    if (cmd.load_seed) begin
      pos_nxt      = START_POS;
      fill_idx_nxt = '0;
      ext_nxt      = use_external;
    end else begin
      if (cmd.fill_step) begin
        fill_idx_nxt = fill_idx_r + ring_idx_t'(1);
      end
      if (cmd.load_out) begin
        pos_nxt = (pos_r == RING_LAST) ? '0 : pos_r + ring_idx_t'(1);
      end
    end
  end

  // Ring write port select
  always_comb begin
    wr_en   = cmd.fill_step | cmd.load_out;
    wr_addr = cmd.fill_step ? fill_idx_r : pos_r;
    wr_data = cmd.fill_step ? lcg_r : sum;
  end

  // Generator state, reset to the power-up seeding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcg_r      <= RESET_SEED;
      fill_idx_r <= '0;
      pos_r      <= START_POS;
      ext_r      <= 1'b0;
    end else begin
      lcg_r      <= lcg_nxt;
      fill_idx_r <= fill_idx_nxt;
      pos_r      <= pos_nxt;
      ext_r      <= ext_nxt;
    end
  end

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_a_r <= ring_mem[pos_r];
      rd_b_r <= ring_mem[other_idx];
    end
  end

  // Output data register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= sum;
    end
  end

  assign stat.fill_last = (fill_idx_r == RING_LAST);
  assign random_value   = out_r;

  `ASSERT_ALWAYS(a_pos_in_ring, pos_r <= RING_LAST, "ring pointer left the ring")
  `ASSERT_IMPL(a_other_in_ring, cmd.rd_en, other_idx <= RING_LAST,
               "lag partner index left the ring")
  `ASSERT_IMPL(a_fill_idx_in_ring, cmd.fill_step, fill_idx_r <= RING_LAST,
               "fill index left the ring")

endmodule

### rtl/core/alrg_ctrl.sv
// ----------------------------------------------------------------------------
// alrg_ctrl
// Sequencer for ring fill, draw read/write and the output handshake.
// ----------------------------------------------------------------------------
module alrg_ctrl import alrg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  `include "assert_macros.svh"

  localparam logic [1:0] ST_FILL  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd) begin
            cmd.load_seed = 1'b1;
            state_nxt     = ST_FILL;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_seed_starts_fill, accept && in_cmd, state_r == ST_FILL,
               "reseed item did not start a ring fill")
  `ASSERT_NEXT(a_draw_goes_write, accept && !in_cmd, state_r == ST_WRITE,
               "draw item did not move to write-back")
  `ASSERT_NEXT(a_write_done, state_r == ST_WRITE && !out_valid_r,
               state_r == ST_IDLE && out_valid_r,
               "write-back stalled with a free output register")
  `ASSERT_IMPL(a_result_from_write, $rose(out_valid_r), $past(state_r) == ST_WRITE,
               "result appeared without a write-back")

endmodule

### rtl/core/additive_lagged_random_generator.sv
// ----------------------------------------------------------------------------
// additive_lagged_random_generator
// Additive lagged generator over a ring of 33 32-bit words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): in_cmd 0 draws a number, 1 reseeds.
//   A reseed latches in_seed_value and in_use_external; a draw reads
//   in_external_byte only when external mode is on.
// Result channel (out_valid/out_ready): one out_random_value per draw,
//   none per reseed.
// Draw: on acceptance its two ring words are read into registers; the
//   write-back state then writes the sum to the ring and the output register.
// Draws: a new item is taken only after the last draw's write-back, since
//   the ring memory is read, then written back. A reseed walks the multiply
//   chain one word per cycle and keeps in_ready low until the ring is full.
// Reset: the ring is filled from seed 34057, normal mode, pointer at 15;
//   this fill runs after rst_n rises, with in_ready low.
// Stall: a finished result waits in the output register; a following draw
//   is accepted and holds in its write-back cycle until the register frees.
// ----------------------------------------------------------------------------
module additive_lagged_random_generator import alrg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_seed_value,
  input  logic        in_use_external,
  input  logic [7:0]  in_external_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_random_value
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer
  alrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // Ring and arithmetic
  alrg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (dp_cmd),
    .stat          (dp_stat),
    .seed_value    (in_seed_value),
    .use_external  (in_use_external),
    .external_byte (in_external_byte),
    .random_value  (out_random_value)
  );

endmodule

### dv/additive_lagged_random_generator_chk.sv
// ----------------------------------------------------------------------------
// additive_lagged_random_generator_chk
// Watches both channels of the lagged generator, keeps its own copy of the
// ring, pointer and mode, predicts each drawn word and compares it with the
// result channel in order. Reports mismatches and the count of open words.
// ----------------------------------------------------------------------------
package alrg_tb_pkg;

  // Input item operations
  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_RESEED = 1'b1
  } alrg_op_e;

endpackage

module additive_lagged_random_generator_chk
  import alrg_pkg::*;
  import alrg_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_seed_value,
  input  logic        in_use_external,
  input  logic [7:0]  in_external_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_random_value,
  output int          mismatches,
  output int          pending
);

  // Predicted generator state
  word_t ring_copy [RING_LEN];
  int    ring_pos;
  logic  ext_mode;

  // Words drawn but not yet seen on the result channel
  word_t expected_words [$];

  // Refill the ring from a seed through the multiply chain
  function automatic void reseed_ring(word_t seed, logic ext);
    ext_mode     = ext;
    ring_pos     = int'(START_POS);
    ring_copy[0] = seed;
    for (int i = 1; i < RING_LEN; i++) begin
      ring_copy[i] = ring_copy[i-1] * LCG_MUL + LCG_ADD;
    end
  endfunction

  // Add the lagged word into the current one, step the pointer
  function automatic word_t draw_word(logic [7:0] ext_byte);
    int lag;
    int other;
    word_t sum;
    if (ext_mode) begin
      lag = int'(LAG_EXT_BASE) + (int'(ext_byte) * LAG_EXT_MUL) % LAG_EXT_MOD;
    end else begin
      lag = int'(LAG_NORMAL);
    end
    other              = (ring_pos + lag) % RING_LEN;
    sum                = ring_copy[ring_pos] + ring_copy[other];
    ring_copy[ring_pos] = sum;
    ring_pos           = (ring_pos + 1) % RING_LEN;
    return sum;
  endfunction

  initial begin
    mismatches = 0;
    pending    = 0;
    reseed_ring(RESET_SEED, 1'b0);
  end

  // Compare first: a result leaving this edge never belongs to an item
  // entering at the same edge
  always @(posedge clk) begin
    word_t want;
    if (!rst_n) begin
      reseed_ring(RESET_SEED, 1'b0);
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item random_value expected none actual %h",
                   $time, out_random_value);
        end else begin
          want = expected_words.pop_front();
          if (out_random_value !== want) begin
            mismatches++;
            $display("%0t: random_value expected %h actual %h",
                     $time, want, out_random_value);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (alrg_op_e'(in_cmd) == CMD_RESEED) begin
          reseed_ring(in_seed_value, in_use_external);
        end else begin
          expected_words.push_back(draw_word(in_external_byte));
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

### dv/additive_lagged_random_generator_tb.sv
// ----------------------------------------------------------------------------
// additive_lagged_random_generator_tb
// Drives draws and reseeds into the lagged generator: a directed set over
// both modes, every external lag and extreme seeds, then random phases with
// and without idle bursts on both channels. The checker predicts each word.
// ----------------------------------------------------------------------------
module additive_lagged_random_generator_tb;
  import alrg_pkg::*;
  import alrg_tb_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_seed_value;
  logic        in_use_external;
  logic [7:0]  in_external_byte;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_random_value;

  int mismatches;
  int pending;
  bit idling;
  int stall_left;

  additive_lagged_random_generator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_seed_value    (in_seed_value),
    .in_use_external  (in_use_external),
    .in_external_byte (in_external_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value)
  );

  additive_lagged_random_generator_chk chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_seed_value    (in_seed_value),
    .in_use_external  (in_use_external),
    .in_external_byte (in_external_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run ceiling, far above the slowest legal run
  initial begin
    #4000000;
    $display("additive_lagged_random_generator: mismatch");
    $finish;
  end

  // Result side back-pressure in random bursts while idling is set
  initial stall_left = 0;
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Present one item, with an optional idle burst ahead of it
  task automatic send_item(alrg_op_e op, logic [31:0] seed, logic ext,
                           logic [7:0] ext_byte);
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= op;
    in_seed_value    <= seed;
    in_use_external  <= ext;
    in_external_byte <= ext_byte;
    do @(posedge clk); while (!in_ready);
  endtask

  // Draw with random values in the fields a draw may ignore
  task automatic send_draw(logic [7:0] ext_byte);
    send_item(CMD_DRAW, $urandom, 1'(($urandom)), ext_byte);
  endtask

  // Hold the sender until every drawn word is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic send_random_item();
    logic [31:0] seed;
    case ($urandom_range(0, 7))
      0:       seed = 32'h0000_0000;
      1:       seed = 32'hFFFF_FFFF;
      default: seed = $urandom;
    endcase
    if ($urandom_range(0, 19) == 0) begin
      send_item(CMD_RESEED, seed, 1'(($urandom)), 8'($urandom));
    end else begin
      send_item(CMD_DRAW, seed, 1'(($urandom)), 8'($urandom));
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_DRAW;
    in_seed_value    = '0;
    in_use_external  = 1'b0;
    in_external_byte = '0;
    out_ready        = 1'b0;
    idling           = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Draws from the reset ring, ignored fields at extremes
    send_item(CMD_DRAW, 32'hFFFF_FFFF, 1'b1, 8'hFF);
    send_item(CMD_DRAW, 32'h0000_0000, 1'b0, 8'h00);
    send_draw(8'($urandom));

    // Zero seed, normal mode
    send_item(CMD_RESEED, 32'h0000_0000, 1'b0, 8'hFF);
    send_draw(8'($urandom));
    send_draw(8'($urandom));

    // All-ones seed, external mode: bytes 0..8 hit every lag 6..14
    send_item(CMD_RESEED, 32'hFFFF_FFFF, 1'b1, 8'h00);
    for (int b = 0; b < 9; b++) begin
      send_item(CMD_DRAW, 32'h0000_0000, 1'b0, 8'(b));
    end
    send_item(CMD_DRAW, 32'hFFFF_FFFF, 1'b1, 8'hFF);

    // Back to the reset seed in normal mode
    send_item(CMD_RESEED, RESET_SEED, 1'b0, 8'h00);
    send_draw(8'hFF);
    send_draw(8'h00);
    wait_drained();

    // Random phases alternate idling on and off; the last one runs without idling
    for (int phase = 0; phase < 4; phase++) begin
      idling = (phase % 2 == 0);
      repeat (175) send_random_item();
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("additive_lagged_random_generator: match");
    end else begin
      $display("additive_lagged_random_generator: mismatch");
    end
    $finish;
  end

endmodule
